[rtl/core/modular_inverse_unit_defines.svh]
// Assertion macros shared by the checker of the modular inverse unit.
// Depends on nothing; included by the checker file.
`ifndef MODULAR_INVERSE_UNIT_DEFINES_SVH
`define MODULAR_INVERSE_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MIU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define MIU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/minv_pkg.sv]
// Package for the modular inverse unit: widths, status codes, FSM states and
// controller/datapath command and status structs. Depends on nothing.
`default_nettype none
package minv_pkg;
  localparam int WORD_BITS = 64;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOINV = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_INIT,
    S_DIV_STEP,
    S_MUL_STEP,
    S_UPDATE,
    S_FINISH,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture value and modulus
    logic div_init;   // start division r0 / r1
    logic div_step;   // one restoring step
    logic mul_init;   // start q * c1
    logic mul_step;   // one shift-add step
    logic update;     // shift remainders and coefficients
    logic finish;     // form result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic range_bad;  // value not below modulus
    logic val_zero;
    logic r1_zero;
    logic cnt_last;   // shared counter at its final step
  } dp_stat_t;
endpackage
`default_nettype wire

[rtl/core/modular_inverse_unit.sv]
// Top level of the modular inverse unit: modulus register, controller and
// datapath. Depends on minv_pkg, minv_ctrl and minv_datapath.
//   channel  handshake             payload
//   config   modulus_we            modulus_wdata[63:0]
//   input    start & !busy         value[63:0]
//   result   done (one cycle)      inverse[63:0], status[1:0]
// Each Euclid step is a bit-serial divide, then a shift-add multiply, up to about
// 93 steps for 64-bit words. Out-of-range and zero inputs are rejected in the check
// state and go from there straight to the result strobe.
// Synchronous reset returns to idle and sets the modulus to one.
// The result strobe cannot be stalled; busy holds off the next item.
`default_nettype none
module modular_inverse_unit (
  input  wire  logic                       clk,
  input  wire  logic                       rst,
  input  wire  logic                       modulus_we,
  input  wire  logic [minv_pkg::WORD_BITS-1:0] modulus_wdata,
  input  wire  logic                       start,
  input  wire  logic [minv_pkg::WORD_BITS-1:0] value,
  output logic                             busy,
  output logic                             done,
  output logic [minv_pkg::WORD_BITS-1:0]   inverse,
  output logic [1:0]                       status
);
  minv_pkg::word_t    modulus;
  minv_pkg::dp_cmd_t  cmd;
  minv_pkg::dp_stat_t stat;
  minv_pkg::word_t    dp_inverse;
  minv_pkg::status_t  dp_status;

  always_ff @(posedge clk) begin
    if (rst)             modulus <= minv_pkg::word_t'(1);
    else if (modulus_we) modulus <= modulus_wdata;
  end

  minv_datapath u_dp (
    .clk(clk), .modulus(modulus), .value(value), .cmd(cmd), .stat(stat),
    .inverse(dp_inverse), .status(dp_status)
  );

  minv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .dp_inverse(dp_inverse),
    .dp_status(dp_status), .cmd(cmd), .busy(busy), .done(done),
    .inverse(inverse), .status(status)
  );
endmodule
`default_nettype wire

[rtl/core/minv_datapath.sv]
// Datapath for the modular inverse: remainder and coefficient registers,
// a bit-serial divider and a shift-add multiplier sharing one counter.
// Depends on minv_pkg.
`default_nettype none
module minv_datapath (
  input  wire                logic clk,
  input  wire                minv_pkg::word_t modulus,
  input  wire                minv_pkg::word_t value,
  input  wire                minv_pkg::dp_cmd_t cmd,
  output minv_pkg::dp_stat_t stat,
  output minv_pkg::word_t    inverse,
  output minv_pkg::status_t  status
);
  localparam int W = minv_pkg::WORD_BITS;

  minv_pkg::word_t m, r0, r1, c0, c1, q, rem, prod, mcand;
  logic            c0_neg, c1_neg;
  minv_pkg::cnt_t  cnt;
  logic [W:0]      trial;
  logic [W:0]      psum;

  // restoring divider: shift one dividend bit (held in q) into rem
  assign trial = {rem, q[W-1]} - {1'b0, r1};
  assign psum  = {1'b0, prod} + {1'b0, c1};

  // shared step counter for divide and multiply
  always_ff @(posedge clk) begin
    if (cmd.div_init || cmd.mul_init)      cnt <= minv_pkg::cnt_t'(W - 1);
    else if (cmd.div_step || cmd.mul_step) cnt <= cnt - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m      <= modulus;
      r0     <= modulus;
      r1     <= value;
      c0     <= '0;
      c1     <= minv_pkg::word_t'(1);
      c0_neg <= 1'b0;
      c1_neg <= 1'b0;
    end
    if (cmd.div_init) begin
      q   <= r0;
      rem <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        q   <= {q[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], q[W-1]};
        q   <= {q[W-2:0], 1'b0};
      end
    end
    if (cmd.mul_init) begin
      // quotient including the bit decided on this last divide step
      mcand <= {q[W-2:0], !trial[W]};
      prod  <= c0;
    end
    if (cmd.mul_step) begin
      // c0 + q*c1: add c1 << k for each set bit of q (low first)
      if (mcand[0]) prod <= psum[W-1:0];
      c1    <= {c1[W-2:0], 1'b0};
      mcand <= {1'b0, mcand[W-1:1]};
    end
    if (cmd.mul_init) begin
      // keep the unshifted c1 for the coefficient swap
      c0 <= c1;
    end
    if (cmd.update) begin
      r0     <= r1;
      r1     <= rem;
      c1     <= prod;
      c0_neg <= c1_neg;
      c1_neg <= !c1_neg;
    end
  end

  // range_bad and val_zero are read in the cycle after load, on the captured item
  assign stat.range_bad = (r1 >= m);
  assign stat.val_zero  = (r1 == '0);
  assign stat.r1_zero   = (r1 == '0);
  assign stat.cnt_last  = (cnt == '0);

  always_comb begin
    inverse = '0;
    status  = minv_pkg::ST_NOINV;
    if (r0 == minv_pkg::word_t'(1)) begin
      status = minv_pkg::ST_OK;
      if (c0_neg && c0 != '0) inverse = m - c0;
      else if (c0 < m)        inverse = c0;
    end
  end
endmodule
`default_nettype wire

[rtl/core/minv_ctrl.sv]
// Controller FSM for the modular inverse: sequences division, multiply and
// update steps and drives the result strobe. Depends on minv_pkg.
`default_nettype none
module minv_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire minv_pkg::dp_stat_t stat,
  input  wire minv_pkg::word_t    dp_inverse,
  input  wire minv_pkg::status_t  dp_status,
  output minv_pkg::dp_cmd_t       cmd,
  output logic                    busy,
  output logic                    done,
  output minv_pkg::word_t         inverse,
  output logic [1:0]              status
);
  minv_pkg::state_t state, state_next;
  minv_pkg::word_t  res_inv;
  minv_pkg::status_t res_st;
  logic             res_set;
  minv_pkg::word_t  set_inv;
  minv_pkg::status_t set_st;

  always_ff @(posedge clk) begin
    if (rst) state <= minv_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      res_inv <= set_inv;
      res_st  <= set_st;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      minv_pkg::S_IDLE:     if (start) state_next = minv_pkg::S_CHECK;
      minv_pkg::S_CHECK: begin
        if (stat.range_bad || stat.val_zero) state_next = minv_pkg::S_DONE;
        else                                 state_next = minv_pkg::S_DIV_INIT;
      end
      minv_pkg::S_DIV_INIT: state_next = stat.r1_zero ? minv_pkg::S_FINISH
                                                       : minv_pkg::S_DIV_STEP;
      minv_pkg::S_DIV_STEP: if (stat.cnt_last) state_next = minv_pkg::S_MUL_STEP;
      minv_pkg::S_MUL_STEP: if (stat.cnt_last) state_next = minv_pkg::S_UPDATE;
      minv_pkg::S_UPDATE:   state_next = minv_pkg::S_DIV_INIT;
      minv_pkg::S_FINISH:   state_next = minv_pkg::S_DONE;
      minv_pkg::S_DONE:     state_next = minv_pkg::S_IDLE;
      default:              state_next = minv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    res_set = 1'b0;
    set_inv = dp_inverse;
    set_st  = dp_status;
    case (state)
      minv_pkg::S_IDLE:     cmd.load = start;
      minv_pkg::S_CHECK: begin
        res_set = stat.range_bad || stat.val_zero;
        set_inv = '0;
        set_st  = stat.range_bad ? minv_pkg::ST_RANGE : minv_pkg::ST_NOINV;
      end
      minv_pkg::S_DIV_INIT: cmd.div_init = !stat.r1_zero;
      minv_pkg::S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        cmd.mul_init = stat.cnt_last;
      end
      minv_pkg::S_MUL_STEP: cmd.mul_step = 1'b1;
      minv_pkg::S_UPDATE:   cmd.update = 1'b1;
      minv_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        res_set    = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy    = (state != minv_pkg::S_IDLE);
  assign done    = (state == minv_pkg::S_DONE);
  assign inverse = done ? res_inv : '0;
  assign status  = done ? res_st : 2'd0;
endmodule
`default_nettype wire

[rtl/core/modular_inverse_unit_checker.sv]
// Port-level checker for the modular inverse unit, bound to the top level.
// Depends on modular_inverse_unit_defines.svh.
`default_nettype none
`include "modular_inverse_unit_defines.svh"
module modular_inverse_unit_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [63:0] inverse,
  input wire logic [1:0]  status
);
  `MIU_ASSERT_NXT(a_accept_busy, start && !busy, busy, "item accepted but not busy")
  `MIU_ASSERT_IMP(a_done_busy, done, busy, "result outside a busy period")
  `MIU_ASSERT_NXT(a_done_single, done, !busy, "busy after result")
  `MIU_ASSERT_IMP(a_bad_zero, done && status != 2'd0, inverse == '0, "nonzero inverse on failure")
  `MIU_ASSERT_IMP(a_status_code, done, status != 2'd3, "illegal status")
endmodule
bind modular_inverse_unit modular_inverse_unit_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .inverse(inverse), .status(status)
);
`default_nettype wire
